### rtl/core/rmra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmra_pkg;

	localparam int BUF_BYTES_DEF   = 4096;
	localparam int NUM_READERS_DEF = 4;

	localparam int CMD_W    = 2;
	localparam int SIZE_W   = 12;
	localparam int RIDX_IN_W = 2;
	localparam int STATUS_W = 3;
	localparam int POFF_W   = 12;
	localparam int PSIZE_W  = 11;
	localparam int RCNT_W   = 3;
	localparam int PEND_W   = 12;
	localparam int NEED_W   = 13;
	localparam int HDR_W    = 16;
	localparam int REFS_W   = 5;

	localparam logic [SIZE_W-1:0] MAX_PAYLOAD = 12'd2047;

	typedef enum logic [CMD_W-1:0] {
		CMD_RESERVE = 2'd0,
		CMD_COMMIT  = 2'd1,
		CMD_READ    = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_SIZE  = 3'd3,
		ST_SEQ   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RSV,
		S_RSV2,
		S_CMT,
		S_RD,
		S_RDCHK,
		S_REL,
		S_REL2,
		S_OUT
	} fsm_t;

endpackage
`default_nettype wire

### rtl/core/rmra_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rmra_cmd_if import rmra_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [SIZE_W-1:0]    record_size;
	logic [RIDX_IN_W-1:0] reader_index;

	modport source (output valid, command, record_size, reader_index, input ready);
	modport sink   (input valid, command, record_size, reader_index, output ready);
endinterface
`default_nettype wire

### rtl/core/rmra_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rmra_res_if import rmra_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POFF_W-1:0]   payload_offset;
	logic [PSIZE_W-1:0]  payload_size;

	modport source (output valid, status, payload_offset, payload_size, input ready);
	modport sink   (input valid, status, payload_offset, payload_size, output ready);
endinterface
`default_nettype wire

### rtl/core/rmra_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rmra_cfg_if import rmra_pkg::*;;
	logic              valid;
	logic              ready;
	logic [RCNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/core/rmra_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rmra_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/multi_reader_record_ring_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake     payload
// cmd      in   valid/ready   command, record_size, reader_index
// res      out  valid/ready   status, payload_offset, payload_size
// cfg      in   valid/ready   data (reader count), always ready
//
// One request at a time: commit runs S_CMT, reserve S_RSV and release S_REL,
// then S_RSV2 or S_REL2 if accepted; read runs S_RD and S_RDCHK, again per
// padding header skipped (at most 3 passes). All end in S_OUT, waiting for
// the result register. Reset clears all positions; the header memory is not
// cleared. A new request is taken while the previous result still waits in
// the output register.
module multi_reader_record_ring_allocator_top import rmra_pkg::*; #(
	parameter int BUF_BYTES   = BUF_BYTES_DEF,
	parameter int NUM_READERS = NUM_READERS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rmra_cmd_if.sink   cmd,
	rmra_res_if.source res,
	rmra_cfg_if.sink   cfg
);
	localparam logic [31:0] RING_LEN = 32'((BUF_BYTES / 8) * 8);
	localparam int HDR_WORDS = BUF_BYTES / 8;
	localparam int SLOT_W    = $clog2(HDR_WORDS);
	localparam int OFF_W     = SLOT_W + 3;
	localparam int RIDX_W    = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

	fsm_t state_q, state_d;

	logic [RCNT_W-1:0]    rcnt_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [SIZE_W-1:0]    size_q;
	logic [RIDX_IN_W-1:0] ridx_q;
	logic [1:0]           pass_q;
	logic [SLOT_W-1:0]    slot_q;

	logic [31:0]       wh_q, wt_q, rt_q, wp_q;
	logic [OFF_W-1:0]  wh_off_q, rt_off_q, wp_off_q;
	logic [PEND_W-1:0] wpend_q;
	logic [31:0]       rpos_q  [NUM_READERS];
	logic [OFF_W-1:0]  roff_q  [NUM_READERS];
	logic [PEND_W-1:0] rpend_q [NUM_READERS];

	logic                res_valid_q;
	logic [STATUS_W-1:0] rstat_q, ostat_q;
	logic [POFF_W-1:0]   rpoff_q, opoff_q;
	logic [PSIZE_W-1:0]  rpsz_q, opsz_q;

	// header memory
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr, ram_raddr;
	logic [HDR_W-1:0]  ram_wdata, ram_rdata;

	rmra_ram #(.WIDTH(HDR_W), .DEPTH(HDR_WORDS)) u_hdr (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared position adder and ring offset adder
	logic [31:0]      add_a, add_b, add_sum;
	logic [OFF_W-1:0] oadd_a, oadd_b, oadd_res;
	logic [OFF_W:0]   oadd_sum;

	assign add_sum  = add_a + add_b;
	assign oadd_sum = {1'b0, oadd_a} + {1'b0, oadd_b};
	assign oadd_res = (oadd_sum >= (OFF_W+1)'(RING_LEN)) ?
		OFF_W'(oadd_sum - (OFF_W+1)'(RING_LEN)) : OFF_W'(oadd_sum);

	// decode
	logic [RIDX_W-1:0] ri;
	logic [RCNT_W-1:0] cnt_use;
	logic              r_ok;
	logic [NEED_W-1:0] rnd13, needed, rd_need;
	logic [31:0]       used;
	logic              size_bad, is_full, do_wrap, rt_near;
	logic [PSIZE_W-1:0] hsize;
	logic [REFS_W-1:0]  hrefs;
	logic              out_free;

	always_comb begin
		ri = RIDX_W'(ridx_q);
		if (rcnt_q == '0) begin
			cnt_use = RCNT_W'(1);
		end else if (32'(rcnt_q) > NUM_READERS) begin
			cnt_use = RCNT_W'(NUM_READERS);
		end else begin
			cnt_use = rcnt_q;
		end
		r_ok     = 32'(ridx_q) < 32'(cnt_use);
		rnd13    = ({1'b0, size_q} + NEED_W'(7)) & ~NEED_W'(7);
		needed   = rnd13 + NEED_W'(8);
		size_bad = (size_q == '0) || (size_q > MAX_PAYLOAD) ||
			(32'(needed) >= (RING_LEN >> 1));
		used     = wh_q - rt_q;
		is_full  = (used >= RING_LEN) || ((RING_LEN - used) <= 32'(needed));
		do_wrap  = (RING_LEN - 32'(wh_off_q)) < 32'(needed);
		rt_near  = 32'(rt_off_q) <= 32'(needed);
		hsize    = ram_rdata[PSIZE_W-1:0];
		hrefs    = ram_rdata[HDR_W-1:PSIZE_W];
		rd_need  = (({2'b00, hsize} + NEED_W'(7)) & ~NEED_W'(7)) + NEED_W'(8);
		out_free = !res_valid_q || res.ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					unique case (cmd_t'(cmd.command))
						CMD_RESERVE: state_d = S_RSV;
						CMD_COMMIT:  state_d = S_CMT;
						CMD_READ:    state_d = S_RD;
						CMD_RELEASE: state_d = S_REL;
					endcase
				end
			end
			S_RSV: begin
				if (size_bad || wpend_q != '0 || is_full || (do_wrap && rt_near)) begin
					state_d = S_OUT;
				end else begin
					state_d = S_RSV2;
				end
			end
			S_RSV2, S_CMT: state_d = S_OUT;
			S_RD: begin
				if (!r_ok || rpend_q[ri] != '0 || rpos_q[ri] == wt_q) begin
					state_d = S_OUT;
				end else begin
					state_d = S_RDCHK;
				end
			end
			S_RDCHK: begin
				if (hsize == '0 && pass_q != 2'd2) begin
					state_d = S_RD;
				end else begin
					state_d = S_OUT;
				end
			end
			S_REL: begin
				if (!r_ok || rpend_q[ri] == '0) begin
					state_d = S_OUT;
				end else begin
					state_d = S_REL2;
				end
			end
			S_REL2: state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd.ready = (state_q == S_IDLE);
		cfg.ready = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = wh_off_q[OFF_W-1:3];
		ram_wdata = '0;
		ram_raddr = roff_q[ri][OFF_W-1:3];
		add_a     = '0;
		add_b     = '0;
		oadd_a    = '0;
		oadd_b    = '0;
		unique case (state_q)
			S_RSV: begin
				// padding header, then jump to the ring boundary
				ram_we = !size_bad && wpend_q == '0 && !is_full && do_wrap;
				add_a  = wh_q;
				add_b  = RING_LEN - 32'(wh_off_q);
			end
			S_RSV2: begin
				ram_we    = 1'b1;
				ram_wdata = {REFS_W'(cnt_use), size_q[PSIZE_W-1:0]};
				add_a     = wh_q;
				add_b     = 32'(needed);
				oadd_a    = wh_off_q;
				oadd_b    = OFF_W'(needed);
			end
			S_CMT: begin
				add_a  = wp_q;
				add_b  = 32'(wpend_q);
				oadd_a = wp_off_q;
				oadd_b = OFF_W'(wpend_q);
			end
			S_RDCHK: begin
				add_a = rpos_q[ri];
				add_b = RING_LEN - 32'(roff_q[ri]);
			end
			S_REL: begin
				add_a  = rpos_q[ri];
				add_b  = 32'(rpend_q[ri]);
				oadd_a = roff_q[ri];
				oadd_b = OFF_W'(rpend_q[ri]);
			end
			S_REL2: begin
				ram_we    = hrefs != '0;
				ram_waddr = slot_q;
				ram_wdata = {hrefs - REFS_W'(1), hsize};
			end
			default: ;
		endcase
		res.valid          = res_valid_q;
		res.status         = ostat_q;
		res.payload_offset = opoff_q;
		res.payload_size   = opsz_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rcnt_q      <= RCNT_W'(1);
			wh_q        <= '0;
			wt_q        <= '0;
			rt_q        <= '0;
			wp_q        <= '0;
			wh_off_q    <= '0;
			rt_off_q    <= '0;
			wp_off_q    <= '0;
			wpend_q     <= '0;
			res_valid_q <= 1'b0;
			pass_q      <= '0;
			for (int i = 0; i < NUM_READERS; i++) begin
				rpos_q[i]  <= '0;
				roff_q[i]  <= '0;
				rpend_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				rcnt_q <= cfg.data;
			end
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: pass_q <= '0;
				S_RSV: begin
					if (!size_bad && wpend_q == '0) begin
						wp_q     <= wh_q;
						wp_off_q <= wh_off_q;
						if (!is_full && do_wrap) begin
							wh_q     <= add_sum;
							wh_off_q <= '0;
							wp_q     <= add_sum;
							wp_off_q <= '0;
						end
					end
				end
				S_RSV2: begin
					wh_q     <= add_sum;
					wh_off_q <= oadd_res;
					wpend_q  <= needed[PEND_W-1:0];
				end
				S_CMT: begin
					if (wpend_q != '0) begin
						wt_q     <= add_sum;
						wp_q     <= add_sum;
						wp_off_q <= oadd_res;
						wpend_q  <= '0;
					end
				end
				S_RDCHK: begin
					if (hsize == '0) begin
						rpos_q[ri] <= add_sum;
						roff_q[ri] <= '0;
						pass_q     <= pass_q + 2'd1;
					end else begin
						rpend_q[ri] <= rd_need[PEND_W-1:0];
					end
				end
				S_REL: begin
					if (r_ok && rpend_q[ri] != '0) begin
						rpos_q[ri]  <= add_sum;
						roff_q[ri]  <= oadd_res;
						rpend_q[ri] <= '0;
					end
				end
				S_REL2: begin
					if (hrefs == REFS_W'(1)) begin
						rt_q     <= rpos_q[ri];
						rt_off_q <= roff_q[ri];
					end
				end
				default: ;
			endcase
		end
	end

	// request capture, staged result and output register
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q  <= cmd.command;
			size_q <= cmd.record_size;
			ridx_q <= cmd.reader_index;
		end
		if (state_q == S_REL) begin
			slot_q <= roff_q[ri][OFF_W-1:3];
		end
		if (state_q == S_OUT && out_free) begin
			ostat_q <= rstat_q;
			opoff_q <= rpoff_q;
			opsz_q  <= rpsz_q;
		end
		unique case (state_q)
			S_RSV: begin
				rpoff_q <= '0;
				rpsz_q  <= '0;
				if (size_bad) begin
					rstat_q <= ST_SIZE;
				end else if (wpend_q != '0) begin
					rstat_q <= ST_SEQ;
				end else if (is_full || (do_wrap && rt_near)) begin
					rstat_q <= ST_FULL;
				end
			end
			S_RSV2: begin
				rstat_q <= ST_OK;
				rpoff_q <= POFF_W'(32'(wh_off_q) + 32'd8);
			end
			S_CMT: begin
				rstat_q <= (cmd_t'(cmd_q) == CMD_COMMIT && wpend_q != '0) ? ST_OK : ST_SEQ;
				rpoff_q <= '0;
				rpsz_q  <= '0;
			end
			S_RD: begin
				rpoff_q <= '0;
				rpsz_q  <= '0;
				if (!r_ok || rpend_q[ri] != '0) begin
					rstat_q <= ST_SEQ;
				end else begin
					rstat_q <= ST_EMPTY;
				end
			end
			S_RDCHK: begin
				if (hsize != '0) begin
					rstat_q <= ST_OK;
					rpoff_q <= POFF_W'(32'(roff_q[ri]) + 32'd8);
					rpsz_q  <= hsize;
				end else begin
					rstat_q <= ST_EMPTY;
				end
			end
			S_REL: begin
				rstat_q <= (!r_ok || rpend_q[ri] == '0) ? ST_SEQ : ST_OK;
				rpoff_q <= '0;
				rpsz_q  <= '0;
			end
			default: ;
		endcase
	end

	// open reservation: head sits exactly one pending length past writer position
	a_pend_span: assert property (@(posedge clk) disable iff (!arst_n)
		wpend_q != '0 |-> (wh_q - wp_q) == 32'(wpend_q))
		else $error("write head and pending length disagree");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("request taken while previous one in progress");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != ST_OK |-> res.payload_offset == '0 && res.payload_size == '0)
		else $error("error result carries payload fields");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_free |=> res.valid && state_q == S_IDLE)
		else $error("result not loaded");

endmodule
`default_nettype wire
